// ===== sv/fpr_pkg.sv =====
package fpr_pkg;

   localparam int FRAME_BYTES_DEF  = 20480;
   localparam int MAX_PACKETS_DEF  = 480;
   localparam int MAX_DATAGRAM_DEF = 2048;

   localparam int          HDR_LEN    = 28;
   localparam logic [15:0] END_ID     = 16'hffff;
   localparam logic [15:0] COUNT_SAT  = 16'hffff;
   localparam logic [31:0] FRAME_NONE = 32'hffffffff;

   localparam logic [1:0] STAT_REJECT = 2'd0;
   localparam logic [1:0] STAT_ACCEPT = 2'd1;
   localparam logic [1:0] STAT_RETRY  = 2'd2;
   localparam logic [1:0] STAT_DONE   = 2'd3;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam int RSP_BITS = 160;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SUM,
      S_CHECK,
      S_MAPCLR,
      S_PLACE,
      S_COPY,
      S_MARK,
      S_COUNT,
      S_FSUM,
      S_FCHECK,
      S_READ,
      S_RESP
   } state_type;

endpackage

// ===== sv/fpr_ram.sv =====
module fpr_ram #(
   parameter int DEPTH = fpr_pkg::MAX_DATAGRAM_DEF,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/frame_packet_reassembler.sv =====
// Frame packet reassembler.
// Input stream (req_): one transaction per datagram byte (tuser = 0, tlast on the
// final byte) or per frame store read (tuser = 1, read_address in tdata).
// Output stream (rsp_): one status transaction per completed datagram and one
// read transaction per read; no transaction for a byte without tlast.
// A byte without tlast is taken in the idle state. The final byte starts a check run:
// the header sum over the datagram bytes, a clear of the received map on a new
// frame id, the payload copy, and on an end packet the missing count over the
// packets and the frame sum over the frame bytes (another map clear on a bad frame
// sum). A read fetches the byte from the frame store before its response. All of
// it runs through one 16-bit accumulator and the read and write ports of the
// staging, frame and map memories, one entry per cycle.
// After reset the block clears the frame store and map with req_tready low.
// req_tready is low while an item is worked on; a result held by a stalled
// receiver parks the next item that produces a result in its final step, and
// req_tready stays low until the held result is taken.
module frame_packet_reassembler #(
   parameter int FRAME_BYTES  = fpr_pkg::FRAME_BYTES_DEF,
   parameter int MAX_PACKETS  = fpr_pkg::MAX_PACKETS_DEF,
   parameter int MAX_DATAGRAM = fpr_pkg::MAX_DATAGRAM_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_byte[7:0], read_address[22:8], zero fill [23]
   input  logic [23:0]  req_tdata,
   // action
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], missing_packets[17:2], current_frame_id[49:18],
   // picture_length[81:50], audio_length[113:82], message_length[145:114],
   // frame_ready[146], read_value[154:147], zero fill [159:155]
   output logic [159:0] rsp_tdata,
   // result_kind
   output logic         rsp_tuser
);

   localparam int FAW = $clog2(FRAME_BYTES);
   localparam int SAW = $clog2(MAX_DATAGRAM);
   localparam int MAW = $clog2(MAX_PACKETS);
   localparam int IW  = (FAW + 1 > 17) ? FAW + 1 : 17;

   fpr_pkg::state_type state_ff, state_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic          over_ff, over_in;
   logic [15:0]   len_ff, len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          pv_ff, pv_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [15:0]   acc_ff, acc_in;
   logic [7:0]    hdr_ff [28];
   logic [7:0]    hdr_in [28];
   logic [31:0]   fnum_ff, fnum_in;
   logic [31:0]   fbytes_ff, fbytes_in;
   logic [31:0]   first_ff, first_in;
   logic [31:0]   second_ff, second_in;
   logic [31:0]   msg_ff, msg_in;
   logic [15:0]   total_ff, total_in;
   logic [15:0]   stdl_ff, stdl_in;
   logic [15:0]   efs_ff, efs_in;
   logic [15:0]   resend_ff, resend_in;
   logic          ready_ff, ready_in;
   logic [31:0]   base_ff, base_in;
   logic          last_ff, last_in;
   logic          clr_fail_ff, clr_fail_in;
   logic [1:0]    status_ff, status_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          kind_ff, kind_in;
   logic [IW-1:0] nlim_ff, nlim_in;
   logic [7:0]    rv_ff, rv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [159:0]  rsp_data_ff, rsp_data_in;

   logic           sb_we;
   logic [SAW-1:0] sb_waddr, sb_raddr;
   logic [7:0]     sb_wdata, sb_q;
   logic           fs_we;
   logic [FAW-1:0] fs_waddr, fs_raddr;
   logic [7:0]     fs_wdata, fs_q;
   logic           mp_we;
   logic [MAW-1:0] mp_waddr, mp_raddr;
   logic [0:0]     mp_wdata, mp_q;

   logic [15:0] add_val;
   logic [15:0] acc_sum;
   logic [15:0] pkt_id;
   logic        is_last_c;
   logic [32:0] cp_addr;
   logic [15:0] cnt_c;
   logic        over_c;
   logic        miss_now;

   fpr_ram #(.DEPTH(MAX_DATAGRAM), .WIDTH(8)) u_stage (
      .clock(clock), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
      .raddr(sb_raddr), .rdata(sb_q)
   );

   fpr_ram #(.DEPTH(FRAME_BYTES), .WIDTH(8)) u_frame (
      .clock(clock), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
      .raddr(fs_raddr), .rdata(fs_q)
   );

   fpr_ram #(.DEPTH(MAX_PACKETS), .WIDTH(1)) u_map (
      .clock(clock), .we(mp_we), .waddr(mp_waddr), .wdata(mp_wdata),
      .raddr(mp_raddr), .rdata(mp_q)
   );

   assign pkt_id    = {hdr_ff[18], hdr_ff[19]};
   assign is_last_c = (total_ff != 16'd0) && (pkt_id == total_ff - 16'd1);
   assign cp_addr   = {1'b0, base_ff} + 33'(pidx_ff) - 33'(fpr_pkg::HDR_LEN);
   assign acc_sum   = acc_ff + add_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpr_pkg::S_CLEAR;
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
         idx_ff       <= '0;
         pv_ff        <= 1'b0;
         fnum_ff      <= fpr_pkg::FRAME_NONE;
         fbytes_ff    <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         msg_ff       <= '0;
         total_ff     <= '0;
         stdl_ff      <= '0;
         efs_ff       <= '0;
         resend_ff    <= '0;
         ready_ff     <= 1'b0;
         clr_fail_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
         idx_ff       <= idx_in;
         pv_ff        <= pv_in;
         fnum_ff      <= fnum_in;
         fbytes_ff    <= fbytes_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         msg_ff       <= msg_in;
         total_ff     <= total_in;
         stdl_ff      <= stdl_in;
         efs_ff       <= efs_in;
         resend_ff    <= resend_in;
         ready_ff     <= ready_in;
         clr_fail_ff  <= clr_fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      pidx_ff     <= pidx_in;
      acc_ff      <= acc_in;
      hdr_ff      <= hdr_in;
      base_ff     <= base_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      rd_ok_ff    <= rd_ok_in;
      kind_ff     <= kind_in;
      nlim_ff     <= nlim_in;
      rv_ff       <= rv_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      acc_in       = acc_ff;
      hdr_in       = hdr_ff;
      fnum_in      = fnum_ff;
      fbytes_in    = fbytes_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      msg_in       = msg_ff;
      total_in     = total_ff;
      stdl_in      = stdl_ff;
      efs_in       = efs_ff;
      resend_in    = resend_ff;
      ready_in     = ready_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      clr_fail_in  = clr_fail_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      kind_in      = kind_ff;
      nlim_in      = nlim_ff;
      rv_in        = rv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      add_val      = 16'd0;
      miss_now     = 1'b0;
      cnt_c        = (cnt_ff == fpr_pkg::COUNT_SAT) ? cnt_ff : cnt_ff + 16'd1;
      over_c       = over_ff || ({1'b0, cnt_ff} >= 17'(MAX_DATAGRAM))
                     || (cnt_ff == fpr_pkg::COUNT_SAT);
      sb_we        = 1'b0;
      sb_waddr     = cnt_ff[SAW-1:0];
      sb_wdata     = req_tdata[7:0];
      sb_raddr     = idx_ff[SAW-1:0];
      fs_we        = 1'b0;
      fs_waddr     = idx_ff[FAW-1:0];
      fs_wdata     = 8'd0;
      fs_raddr     = idx_ff[FAW-1:0];
      mp_we        = 1'b0;
      mp_waddr     = idx_ff[MAW-1:0];
      mp_wdata     = 1'b0;
      mp_raddr     = idx_ff[MAW-1:0];

      unique case (state_ff)
         fpr_pkg::S_CLEAR: begin
            fs_we = 1'b1;
            mp_we = (idx_ff < IW'(MAX_PACKETS));
            if (idx_ff == IW'(FRAME_BYTES - 1)) begin
               idx_in   = '0;
               state_in = fpr_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fpr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            fs_raddr   = FAW'(req_tdata[22:8]);
            if (req_tvalid) begin
               if (req_tuser == fpr_pkg::KIND_READ) begin
                  rd_ok_in  = ready_ff && (17'(req_tdata[22:8]) < 17'(FRAME_BYTES));
                  kind_in   = fpr_pkg::KIND_READ;
                  status_in = fpr_pkg::STAT_REJECT;
                  state_in  = fpr_pkg::S_READ;
               end else begin
                  sb_we = ({1'b0, cnt_ff} < 17'(MAX_DATAGRAM));
                  if (req_tlast) begin
                     len_in  = cnt_c;
                     cnt_in  = '0;
                     over_in = 1'b0;
                     kind_in = fpr_pkg::KIND_BYTE;
                     rv_in   = 8'd0;
                     if (over_c || cnt_c < 16'(fpr_pkg::HDR_LEN)
                         || {1'b0, cnt_c} > 17'(MAX_DATAGRAM)) begin
                        status_in = fpr_pkg::STAT_REJECT;
                        state_in  = fpr_pkg::S_RESP;
                     end else begin
                        idx_in   = '0;
                        pv_in    = 1'b0;
                        acc_in   = '0;
                        state_in = fpr_pkg::S_SUM;
                     end
                  end else begin
                     cnt_in  = cnt_c;
                     over_in = over_c;
                  end
               end
            end
         end
         fpr_pkg::S_SUM: begin
            if (pv_ff) begin
               if (pidx_ff != IW'(26) && pidx_ff != IW'(27)) begin
                  add_val = {8'd0, sb_q};
               end
               if (pidx_ff < IW'(fpr_pkg::HDR_LEN)) begin
                  hdr_in[pidx_ff[4:0]] = sb_q;
               end
            end
            acc_in = acc_sum;
            pv_in  = 1'b0;
            if (idx_ff < IW'(len_ff)) begin
               pv_in   = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else if (!pv_ff) begin
               state_in = fpr_pkg::S_CHECK;
            end
         end
         fpr_pkg::S_CHECK: begin
            if (acc_ff != {hdr_ff[26], hdr_ff[27]} || {hdr_ff[22], hdr_ff[23]} != len_ff) begin
               status_in = fpr_pkg::STAT_REJECT;
               state_in  = fpr_pkg::S_RESP;
            end else if ({hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]} != fnum_ff) begin
               fnum_in     = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]};
               fbytes_in   = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]};
               first_in    = {hdr_ff[8], hdr_ff[9], hdr_ff[10], hdr_ff[11]};
               second_in   = {hdr_ff[12], hdr_ff[13], hdr_ff[14], hdr_ff[15]};
               msg_in      = {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]}
                             - {hdr_ff[8], hdr_ff[9], hdr_ff[10], hdr_ff[11]}
                             - {hdr_ff[12], hdr_ff[13], hdr_ff[14], hdr_ff[15]};
               total_in    = {hdr_ff[16], hdr_ff[17]};
               stdl_in     = {hdr_ff[20], hdr_ff[21]};
               efs_in      = {hdr_ff[24], hdr_ff[25]};
               ready_in    = 1'b0;
               idx_in      = '0;
               clr_fail_in = 1'b0;
               state_in    = fpr_pkg::S_MAPCLR;
            end else begin
               state_in = fpr_pkg::S_PLACE;
            end
         end
         fpr_pkg::S_MAPCLR: begin
            mp_we = 1'b1;
            if (idx_ff == IW'(MAX_PACKETS - 1)) begin
               idx_in = '0;
               if (clr_fail_ff) begin
                  status_in = fpr_pkg::STAT_RETRY;
                  state_in  = fpr_pkg::S_RESP;
               end else begin
                  state_in = fpr_pkg::S_PLACE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         fpr_pkg::S_PLACE: begin
            last_in = is_last_c;
            if (pkt_id < total_ff) begin
               if (fbytes_ff > 32'(FRAME_BYTES - fpr_pkg::HDR_LEN)) begin
                  status_in = fpr_pkg::STAT_REJECT;
                  state_in  = fpr_pkg::S_RESP;
               end else if (!(stdl_ff == len_ff || is_last_c)) begin
                  status_in = fpr_pkg::STAT_REJECT;
                  state_in  = fpr_pkg::S_RESP;
               end else begin
                  base_in  = 32'(pkt_id) * 32'(stdl_ff - 16'(fpr_pkg::HDR_LEN));
                  idx_in   = IW'(fpr_pkg::HDR_LEN);
                  pv_in    = 1'b0;
                  state_in = fpr_pkg::S_COPY;
               end
            end else begin
               state_in = fpr_pkg::S_MARK;
            end
         end
         fpr_pkg::S_COPY: begin
            fs_waddr = cp_addr[FAW-1:0];
            fs_wdata = sb_q;
            fs_we    = pv_ff && (cp_addr < 33'(FRAME_BYTES));
            pv_in    = 1'b0;
            if (idx_ff < IW'(len_ff)) begin
               pv_in   = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else if (!pv_ff) begin
               state_in = fpr_pkg::S_MARK;
            end
         end
         fpr_pkg::S_MARK: begin
            mp_waddr = pkt_id[MAW-1:0];
            mp_wdata = 1'b1;
            mp_we    = (pkt_id < total_ff) && (17'(pkt_id) < 17'(MAX_PACKETS));
            if (last_ff || pkt_id == fpr_pkg::END_ID) begin
               idx_in   = '0;
               acc_in   = '0;
               pv_in    = 1'b0;
               state_in = fpr_pkg::S_COUNT;
            end else begin
               status_in = fpr_pkg::STAT_ACCEPT;
               state_in  = fpr_pkg::S_RESP;
            end
         end
         fpr_pkg::S_COUNT: begin
            pv_in = 1'b0;
            if (idx_ff < IW'(total_ff)) begin
               if (idx_ff < IW'(MAX_PACKETS)) begin
                  pv_in = 1'b1;
               end else begin
                  miss_now = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else if (!pv_ff) begin
               resend_in = acc_ff;
               if (acc_ff != 16'd0) begin
                  status_in = fpr_pkg::STAT_RETRY;
                  state_in  = fpr_pkg::S_RESP;
               end else begin
                  idx_in   = '0;
                  nlim_in  = (fbytes_ff < 32'(FRAME_BYTES)) ? fbytes_ff[IW-1:0]
                                                            : IW'(FRAME_BYTES);
                  state_in = fpr_pkg::S_FSUM;
               end
            end
            add_val = 16'({pv_ff && !mp_q[0]}) + 16'(miss_now);
            acc_in  = acc_sum;
         end
         fpr_pkg::S_FSUM: begin
            if (pv_ff) begin
               add_val = {8'd0, fs_q};
            end
            acc_in = acc_sum;
            pv_in  = 1'b0;
            if (idx_ff < nlim_ff) begin
               pv_in  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!pv_ff) begin
               state_in = fpr_pkg::S_FCHECK;
            end
         end
         fpr_pkg::S_FCHECK: begin
            if (acc_ff == efs_ff) begin
               ready_in  = 1'b1;
               status_in = fpr_pkg::STAT_DONE;
               state_in  = fpr_pkg::S_RESP;
            end else begin
               resend_in   = total_ff;
               clr_fail_in = 1'b1;
               idx_in      = '0;
               state_in    = fpr_pkg::S_MAPCLR;
            end
         end
         fpr_pkg::S_READ: begin
            rv_in    = rd_ok_ff ? fs_q : 8'd0;
            state_in = fpr_pkg::S_RESP;
         end
         fpr_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_data_in  = {5'd0, rv_ff, ready_ff, msg_ff, second_ff, first_ff,
                               fnum_ff, resend_ff, status_ff};
               state_in     = fpr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fpr_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == fpr_pkg::KIND_BYTE && req_tlast
      |=> !req_tready)
      else $error("block took an item during a datagram check");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fpr_pkg::KIND_READ && !rsp_tdata[146]
      |-> rsp_tdata[154:147] == 8'd0)
      else $error("read returned data while the frame is not ready");

   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fpr_pkg::KIND_BYTE && rsp_tdata[1:0] == fpr_pkg::STAT_DONE
      |-> rsp_tdata[146] && rsp_tdata[17:2] == 16'd0)
      else $error("complete status without ready frame");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input taken before the store clear finished");

endmodule
